// ===== src/rbb_pkg.sv =====
`default_nettype none
package rbb_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int SIZE_W     = 8;
  localparam int CH_W       = 8;
  localparam int COLSUM_W   = CH_W + 2;
  localparam int TOTAL_W    = CH_W + 4;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SH   = 16;
  localparam int PROD_W     = TOTAL_W + RECIP_W;
  localparam int NCELL      = 3;

  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam logic [SIZE_W-1:0]  MIN_SIZE   = 8'd3;
  localparam logic [SIZE_W-1:0]  MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]  MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] red;
    logic [COLSUM_W-1:0] green;
    logic [COLSUM_W-1:0] blue;
  } colsum_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] red;
    logic [TOTAL_W-1:0] green;
    logic [TOTAL_W-1:0] blue;
  } total_t;

  typedef struct packed {
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
    logic             frame_done;
  } tag_t;

  typedef struct packed {
    logic            frame_start;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
    logic             frame_done;
  } out_beat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    if (v < MIN_SIZE) begin
      res = MIN_SIZE;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // floor(x / 9) via reciprocal, exact for x up to 9 * 255
  function automatic logic [CH_W-1:0] div9(input logic [TOTAL_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(DIV9_RECIP);
    return prod[RECIP_SH +: CH_W];
  endfunction

  function automatic logic [COLSUM_W-1:0] add3(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [CH_W-1:0] c);
    return COLSUM_W'(a) + COLSUM_W'(b) + COLSUM_W'(c);
  endfunction

endpackage
`default_nettype wire

// ===== src/rgb_box_blur_3x3.sv =====
// rgb_box_blur_3x3: streaming 3x3 mean filter on RGB pixels.
// Input channel (in_valid/in_ready/in_data) takes one pixel per beat in raster
// order; frame_start on a beat forces that pixel to row 0, column 0, and the
// position wraps by itself after the last pixel of a frame.
// Result channel (out_valid/out_ready/out_data) carries one beat per interior
// centre: floor of each channel's nine-pixel sum over 9, the centre row and
// column, and frame_done on the last interior centre. Border pixels give none.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes frame_width
// (index 0) or frame_height (index 1); a write restarts the position at 0,0.
// Sizes below 3 act as 3, above 128 as 128. Write only while the block is idle.
// Throughput: one pixel per clock while the receiver keeps up. The pixel that
// completes a window passes stage a (line store read), the window cells, the
// sum adder, then the reciprocal multiply into the output register.
// A stalled receiver freezes the whole pipeline; in_ready follows out_ready
// when the output register holds a result. Line stores are not cleared, as
// a never-written entry only feeds border positions.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the position
// and sets both sizes to 128.
`default_nettype none
module rgb_box_blur_3x3 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rbb_pkg::in_beat_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rbb_pkg::out_beat_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rbb_pkg::SIZE_W-1:0]  cfg_data
);

  logic [rbb_pkg::SIZE_W-1:0] width_r;
  logic [rbb_pkg::SIZE_W-1:0] height_r;
  logic [rbb_pkg::SIZE_W-1:0] w;
  logic [rbb_pkg::SIZE_W-1:0] h;
  logic [rbb_pkg::POS_W-1:0]  row_r, row_nxt;
  logic [rbb_pkg::POS_W-1:0]  col_r, col_nxt;
  logic [rbb_pkg::POS_W-1:0]  row_cur, col_cur;
  logic [rbb_pkg::POS_W-1:0]  row_pos, col_pos;
  logic                       en;
  logic                       acc;
  logic                       emit;
  rbb_pkg::tag_t              tag_cur;

  logic                       a_vld_r;
  logic                       a_emit_r;
  rbb_pkg::pix_t              a_pix_r;
  logic [rbb_pkg::POS_W-1:0]  a_col_r;
  rbb_pkg::tag_t              a_tag_r;
  rbb_pkg::column_t           above;
  rbb_pkg::column_t           wr_col;
  rbb_pkg::column_t           new_col;

  logic                       b_vld_r;
  rbb_pkg::tag_t              b_tag_r;
  rbb_pkg::column_t           col_chain [rbb_pkg::NCELL+1];
  rbb_pkg::colsum_t           cell_sum  [rbb_pkg::NCELL];

  logic                       c_vld_r;
  rbb_pkg::tag_t              c_tag_r;
  rbb_pkg::total_t            c_sum_r;

  logic                       out_vld_r;
  rbb_pkg::out_beat_t         out_data_r;

  assign w = rbb_pkg::clamp_size(width_r,  rbb_pkg::MAX_W_SIZE);
  assign h = rbb_pkg::clamp_size(height_r, rbb_pkg::MAX_H_SIZE);

  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign acc       = in_valid && en;
  assign cfg_ready = 1'b1;

  // position of the incoming pixel
  always_comb begin
    row_cur = in_data.frame_start ? '0 : row_r;
    col_cur = in_data.frame_start ? '0 : col_r;
    col_pos = ({1'b0, col_cur} >= w) ? '0 : col_cur;
    row_pos = ({1'b0, row_cur} >= h) ? '0 : row_cur;
    emit    = (row_pos >= rbb_pkg::POS_W'(2)) && (col_pos >= rbb_pkg::POS_W'(2));
    tag_cur.centre_row = row_pos - rbb_pkg::POS_W'(1);
    tag_cur.centre_col = col_pos - rbb_pkg::POS_W'(1);
    tag_cur.frame_done = ({1'b0, row_pos} == h - 8'd1) && ({1'b0, col_pos} == w - 8'd1);
    if ({1'b0, col_pos} + 8'd1 >= w) begin
      col_nxt = '0;
      row_nxt = ({1'b0, row_pos} + 8'd1 >= h) ? '0 : row_pos + rbb_pkg::POS_W'(1);
    end else begin
      col_nxt = col_pos + rbb_pkg::POS_W'(1);
      row_nxt = row_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rbb_pkg::MAX_W_SIZE;
      height_r <= rbb_pkg::MAX_H_SIZE;
      row_r    <= '0;
      col_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbb_pkg::CFG_FRAME_WIDTH: begin
          width_r <= cfg_data;
          row_r   <= '0;
          col_r   <= '0;
        end
        rbb_pkg::CFG_FRAME_HEIGHT: begin
          height_r <= cfg_data;
          row_r    <= '0;
          col_r    <= '0;
        end
        default: ;
      endcase
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage a: pixel waits for its line store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_emit_r      <= emit;
      a_pix_r.red   <= in_data.in_red;
      a_pix_r.green <= in_data.in_green;
      a_pix_r.blue  <= in_data.in_blue;
      a_col_r       <= col_pos;
      a_tag_r       <= tag_cur;
    end
  end

  always_comb begin
    wr_col.top  = above.mid;
    wr_col.mid  = a_pix_r;
    wr_col.bot  = '0;
    new_col.top = above.top;
    new_col.mid = above.mid;
    new_col.bot = a_pix_r;
  end

  rbb_line_store u_line_store (
    .clk     (clk),
    .wr_en   (en && a_vld_r),
    .wr_addr (a_col_r),
    .wr_data (wr_col),
    .rd_en   (acc),
    .rd_addr (col_pos),
    .rd_data (above)
  );

  // stage b: window as a chain of column cells, newest first
  assign col_chain[0] = new_col;

  for (genvar i = 0; i < rbb_pkg::NCELL; i++) begin : g_cell
    rbb_cell u_cell (
      .clk     (clk),
      .shift   (en && a_vld_r),
      .col_in  (col_chain[i]),
      .col_out (col_chain[i+1]),
      .sum_out (cell_sum[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r && a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_tag_r <= a_tag_r;
    end
  end

  // stage c: window sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_tag_r       <= b_tag_r;
      c_sum_r.red   <= rbb_pkg::TOTAL_W'(cell_sum[0].red) +
                       rbb_pkg::TOTAL_W'(cell_sum[1].red) +
                       rbb_pkg::TOTAL_W'(cell_sum[2].red);
      c_sum_r.green <= rbb_pkg::TOTAL_W'(cell_sum[0].green) +
                       rbb_pkg::TOTAL_W'(cell_sum[1].green) +
                       rbb_pkg::TOTAL_W'(cell_sum[2].green);
      c_sum_r.blue  <= rbb_pkg::TOTAL_W'(cell_sum[0].blue) +
                       rbb_pkg::TOTAL_W'(cell_sum[1].blue) +
                       rbb_pkg::TOTAL_W'(cell_sum[2].blue);
    end
  end

  // output register: divide by nine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.out_red    <= rbb_pkg::div9(c_sum_r.red);
      out_data_r.out_green  <= rbb_pkg::div9(c_sum_r.green);
      out_data_r.out_blue   <= rbb_pkg::div9(c_sum_r.blue);
      out_data_r.centre_row <= c_tag_r.centre_row;
      out_data_r.centre_col <= c_tag_r.centre_col;
      out_data_r.frame_done <= c_tag_r.frame_done;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== src/rbb_line_store.sv =====
`default_nettype none
module rbb_line_store (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [rbb_pkg::POS_W-1:0]    wr_addr,
  input  wire rbb_pkg::column_t             wr_data,
  input  wire logic                         rd_en,
  input  wire logic [rbb_pkg::POS_W-1:0]    rd_addr,
  output rbb_pkg::column_t                  rd_data
);

  // two previous rows per column, packed in one word (bot lane unused)
  rbb_pkg::column_t mem [rbb_pkg::MAX_WIDTH];
  rbb_pkg::column_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== src/rbb_cell.sv =====
`default_nettype none
module rbb_cell (
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire rbb_pkg::column_t  col_in,
  output rbb_pkg::column_t       col_out,
  output rbb_pkg::colsum_t       sum_out
);

  rbb_pkg::column_t col_r;
  rbb_pkg::colsum_t sum_r;
  rbb_pkg::colsum_t sum_nxt;

  always_comb begin
    sum_nxt.red   = rbb_pkg::add3(col_in.top.red,   col_in.mid.red,   col_in.bot.red);
    sum_nxt.green = rbb_pkg::add3(col_in.top.green, col_in.mid.green, col_in.bot.green);
    sum_nxt.blue  = rbb_pkg::add3(col_in.top.blue,  col_in.mid.blue,  col_in.bot.blue);
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum_out = sum_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PIXEL_TARGET = 1450;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_CAP    = 400;
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  class blur_scoreboard;
    logic [rbb_pkg::SIZE_W-1:0] width_reg;
    logic [rbb_pkg::SIZE_W-1:0] height_reg;
    rbb_pkg::pix_t line_a[rbb_pkg::MAX_WIDTH];
    rbb_pkg::pix_t line_b[rbb_pkg::MAX_WIDTH];
    rbb_pkg::pix_t win[9];
    int unsigned row_pos;
    int unsigned col_pos;
    rbb_pkg::out_beat_t expected_blurs[$];
    int fails;

    function new();
      width_reg = rbb_pkg::SIZE_W'(rbb_pkg::MAX_WIDTH);
      height_reg = rbb_pkg::SIZE_W'(rbb_pkg::MAX_HEIGHT);
      foreach (line_a[i]) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      foreach (win[i]) begin
        win[i] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      fails = 0;
    endfunction

    function int unsigned bounded(logic [rbb_pkg::SIZE_W-1:0] v, int unsigned top);
      if (v < 3) begin
        return 3;
      end
      if (v > top) begin
        return top;
      end
      return 32'(v);
    endfunction

    function void set_reg(logic [1:0] idx, logic [rbb_pkg::SIZE_W-1:0] val);
      if (idx == rbb_pkg::CFG_FRAME_WIDTH) begin
        width_reg = val;
      end else if (idx == rbb_pkg::CFG_FRAME_HEIGHT) begin
        height_reg = val;
      end else begin
        return;
      end
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int pending();
      return expected_blurs.size();
    endfunction

    function void note_pixel(rbb_pkg::in_beat_t b);
      int unsigned w, h, r, c, sum_r, sum_g, sum_b;
      int k;
      rbb_pkg::pix_t above1, above2;
      rbb_pkg::out_beat_t res;
      w = bounded(width_reg, rbb_pkg::MAX_WIDTH);
      h = bounded(height_reg, rbb_pkg::MAX_HEIGHT);
      if (b.frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (col_pos >= w) begin
        col_pos = 0;
      end
      if (row_pos >= h) begin
        row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      above1 = line_a[c];
      above2 = line_b[c];
      for (k = 0; k < 3; k++) begin
        win[k*3] = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = '{red: b.in_red, green: b.in_green, blue: b.in_blue};
      line_b[c] = above1;
      line_a[c] = win[8];
      if (r >= 2 && c >= 2) begin
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (k = 0; k < 9; k++) begin
          sum_r += 32'(win[k].red);
          sum_g += 32'(win[k].green);
          sum_b += 32'(win[k].blue);
        end
        res.out_red = rbb_pkg::CH_W'(sum_r / 9);
        res.out_green = rbb_pkg::CH_W'(sum_g / 9);
        res.out_blue = rbb_pkg::CH_W'(sum_b / 9);
        res.centre_row = rbb_pkg::POS_W'(r - 1);
        res.centre_col = rbb_pkg::POS_W'(c - 1);
        res.frame_done = (r == h - 1) && (c == w - 1);
        expected_blurs.push_back(res);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(rbb_pkg::out_beat_t got);
      rbb_pkg::out_beat_t want;
      if (expected_blurs.size() == 0) begin
        $error("unexpected result beat at row %0d col %0d", got.centre_row, got.centre_col);
        fails++;
        return;
      end
      want = expected_blurs.pop_front();
      compare_field("out_red", 32'(want.out_red), 32'(got.out_red));
      compare_field("out_green", 32'(want.out_green), 32'(got.out_green));
      compare_field("out_blue", 32'(want.out_blue), 32'(got.out_blue));
      compare_field("centre_row", 32'(want.centre_row), 32'(got.centre_row));
      compare_field("centre_col", 32'(want.centre_col), 32'(got.centre_col));
      compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rbb_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  rbb_pkg::out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [rbb_pkg::SIZE_W-1:0] cfg_data;

  blur_scoreboard sb;
  int pixels_sent = 0;
  int rx_stall_pct = 0;
  bit long_hold = 1'b0;
  bit calm = 1'b0;
  int unsigned cycle_count = 0;

  rgb_box_blur_3x3 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if (in_valid && in_ready) begin
        sb.note_pixel(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
      end
    end
  end

  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        n = HOLD_CYCLES;
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 6);
      end else begin
        out_ready <= 1'b1;
        n = 1;
      end
      repeat (n) @(negedge clk);
    end
  end

  function automatic logic [rbb_pkg::CH_W-1:0] random_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rbb_pkg::CH_W'($urandom);
    endcase
  endfunction

  function automatic rbb_pkg::in_beat_t random_pixel(logic start);
    rbb_pkg::in_beat_t px;
    px.frame_start = start;
    px.in_red = random_level();
    px.in_green = random_level();
    px.in_blue = random_level();
    return px;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [rbb_pkg::SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(rbb_pkg::in_beat_t px);
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  // drop valid, wait for all outstanding blurs, then idle before returning
  task automatic settle(int extra);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic stream(int count, int gap_pct);
    rbb_pkg::in_beat_t px;
    logic start;
    for (int i = 0; i < count; i++) begin
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      // mostly frame_start at frame origin, rarely anywhere as noise
      start = (sb.row_pos == 0 && sb.col_pos == 0 && $urandom_range(0, 3) != 0) ||
              ($urandom_range(0, 79) == 0);
      px = random_pixel(start);
      send_pixel(px);
    end
  endtask

  initial begin : stimulus
    int w_eff, h_eff, count, sel;
    logic [rbb_pkg::SIZE_W-1:0] w_raw, h_raw;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = rbb_pkg::CFG_FRAME_WIDTH;
    cfg_data = '0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // smallest frame, sizes below the minimum
    write_reg(rbb_pkg::CFG_FRAME_WIDTH, 8'd0);
    write_reg(rbb_pkg::CFG_FRAME_HEIGHT, 8'd1);
    for (int i = 0; i < 9; i++) begin
      send_pixel('{i == 0, 8'hFF, 8'hFF, 8'hFF});
    end
    // next frame by wrap, no frame_start
    for (int i = 0; i < 9; i++) begin
      send_pixel('{1'b0, (i % 2) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hAA : 8'h55,
                   rbb_pkg::CH_W'(i * 29)});
    end
    // partial frame cut short by frame_start
    for (int i = 0; i < 12; i++) begin
      send_pixel(random_pixel(i == 3));
    end
    settle(DRAIN_CYCLES);

    // long receiver hold-off, then a mid-phase drain pause
    rx_stall_pct = 0;
    write_reg(rbb_pkg::CFG_FRAME_WIDTH, 8'd6);
    write_reg(rbb_pkg::CFG_FRAME_HEIGHT, 8'd5);
    long_hold = 1'b1;
    stream(100, 0);
    settle(1);
    rx_stall_pct = 25;
    stream(50, 25);

    while (pixels_sent < PIXEL_TARGET - 120) begin
      settle(DRAIN_CYCLES);
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
        w_raw = ($urandom_range(0, 1)) ? rbb_pkg::SIZE_W'($urandom_range(129, 255)) :
                                         rbb_pkg::MAX_W_SIZE;
        h_raw = rbb_pkg::SIZE_W'($urandom_range(0, 3));
      end else if (sel == 1) begin
        w_raw = rbb_pkg::SIZE_W'($urandom_range(0, 3));
        h_raw = ($urandom_range(0, 1)) ? 8'hFF : rbb_pkg::MAX_H_SIZE;
      end else begin
        w_raw = rbb_pkg::SIZE_W'($urandom_range(3, 12));
        h_raw = rbb_pkg::SIZE_W'($urandom_range(3, 9));
      end
      if (sel < 2 || $urandom_range(0, 3) != 0) begin
        write_reg(rbb_pkg::CFG_FRAME_WIDTH, w_raw);
      end
      if (sel < 2 || $urandom_range(0, 3) != 0) begin
        write_reg(rbb_pkg::CFG_FRAME_HEIGHT, h_raw);
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(($urandom_range(0, 1)) ? CFG_SPARE_2 : CFG_SPARE_3,
                  rbb_pkg::SIZE_W'($urandom));
      end
      rx_stall_pct = 25 * $urandom_range(0, 2);
      w_eff = sb.bounded(sb.width_reg, rbb_pkg::MAX_WIDTH);
      h_eff = sb.bounded(sb.height_reg, rbb_pkg::MAX_HEIGHT);
      count = w_eff * h_eff * $urandom_range(1, 3) + $urandom_range(0, w_eff);
      if (count > PHASE_CAP) begin
        count = PHASE_CAP;
      end
      if (count > PIXEL_TARGET - 120 - pixels_sent) begin
        count = PIXEL_TARGET - 120 - pixels_sent;
      end
      stream(count, 25 * $urandom_range(0, 2));
    end

    // closing stretch at full rate on both sides
    settle(DRAIN_CYCLES);
    calm = 1'b1;
    write_reg(rbb_pkg::CFG_FRAME_WIDTH, rbb_pkg::SIZE_W'($urandom_range(4, 10)));
    write_reg(rbb_pkg::CFG_FRAME_HEIGHT, rbb_pkg::SIZE_W'($urandom_range(3, 8)));
    stream(120, 0);
    settle(2 * DRAIN_CYCLES);

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
